// ===== design/byte_stream_lexer_core_assert.svh =====
// Assertion macros for the byte stream lexer.
// Each macro clocks on clk and is disabled while arst_n is low.
`ifndef BYTE_STREAM_LEXER_CORE_ASSERT_SVH
`define BYTE_STREAM_LEXER_CORE_ASSERT_SVH

// Same-cycle implication
`define BSL_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define BSL_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/bsl_pkg.sv =====
// Shared types and constants for the byte stream lexer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package bsl_pkg;

	// Request payload: one source byte
	typedef struct packed {
		logic [7:0] input_byte;
		logic       end_of_input;
	} in_req_t;

	// Result payload: one token
	typedef struct packed {
		logic [4:0]  token_kind;
		logic [15:0] token_offset;
		logic [15:0] token_length;
		logic        last_of_run;
	} tok_t;

	// Token kinds
	localparam logic [4:0] KIND_DOT        = 5'd6;
	localparam logic [4:0] KIND_OPBASE     = 5'd11;
	localparam logic [4:0] KIND_BANG_EQ    = 5'd12;
	localparam logic [4:0] KIND_EQ_EQ      = 5'd14;
	localparam logic [4:0] KIND_LESS_EQ    = 5'd16;
	localparam logic [4:0] KIND_GREATER_EQ = 5'd18;
	localparam logic [4:0] KIND_IDENT      = 5'd19;
	localparam logic [4:0] KIND_NUMBER     = 5'd20;
	localparam logic [4:0] KIND_LET        = 5'd21;
	localparam logic [4:0] KIND_ERROR      = 5'd22;
	localparam logic [4:0] KIND_EOF        = 5'd23;

	// Characters with special meaning
	localparam logic [7:0] CH_NUL        = 8'h00;
	localparam logic [7:0] CH_L          = 8'h6C;
	localparam logic [7:0] CH_E          = 8'h65;
	localparam logic [7:0] CH_T          = 8'h74;
	localparam logic [7:0] CH_EQ         = 8'h3D;
	localparam logic [7:0] CH_DOT        = 8'h2E;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

	localparam logic [15:0] LEN_MAX = 16'hFFFF;

	// Up to three tokens per byte
	localparam int MAX_TOK = 3;

	// Token queue geometry
	localparam int TQ_DEPTH = 8;
	localparam int TQ_PTR_W = 3;
	localparam int TQ_CNT_W = 4;

endpackage

`default_nettype wire

// ===== design/bsl_scan.sv =====
// Scanner state and per-byte token decision for the byte stream lexer.
// Depends on bsl_pkg for payload types, token kinds and characters.
`timescale 1ns / 1ps
`default_nettype none

module bsl_scan
	import bsl_pkg::*;
#(
	parameter int POS_WIDTH = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 step,
	input  wire in_req_t              req,
	output tok_t [MAX_TOK-1:0]        toks,
	output logic [1:0]                tok_cnt
);

	typedef enum logic [5:0] {
		MODE_IDLE   = 6'b000001,
		MODE_IDENT  = 6'b000010,
		MODE_NUM    = 6'b000100,
		MODE_NUMDOT = 6'b001000,
		MODE_FRAC   = 6'b010000,
		MODE_OP     = 6'b100000
	} mode_t;

	mode_t                 mode_q, mode_n;
	logic [1:0]            pend_op_q, pend_op_n;
	logic [POS_WIDTH-1:0]  start_pos_q, start_pos_n;
	logic [POS_WIDTH-1:0]  cur_pos_q, cur_pos_n;
	logic [1:0]            kw_prog_q, kw_prog_n;
	logic                  kw_alive_q, kw_alive_n;
	logic [15:0]           open_len_q, open_len_n;

	logic [7:0] c;
	logic       is_end, is_ws, is_alpha, is_digit, punct_hit, op_hit;
	logic [3:0] punct_idx;
	logic [1:0] op_idx;

	function automatic logic [15:0] sat_add(input logic [15:0] len, input logic [1:0] by);
		logic [16:0] s;
		s = {1'b0, len} + 17'(by);
		return s[16] ? LEN_MAX : s[15:0];
	endfunction

	function automatic tok_t mk_tok(input logic [4:0] kind, input logic [15:0] off,
		input logic [15:0] len);
		tok_t t;
		t.token_kind   = kind;
		t.token_offset = off;
		t.token_length = len;
		t.last_of_run  = 1'b0;
		return t;
	endfunction

	// Character classes
	always_comb begin
		c        = req.input_byte;
		is_end   = req.end_of_input || (c == CH_NUL);
		is_ws    = (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
		is_alpha = (c inside {[8'h61:8'h7A], [8'h41:8'h5A]}) || (c == CH_UNDERSCORE);
		is_digit = c inside {[8'h30:8'h39]};
		punct_hit = 1'b1;
		case (c)
			8'h28:   punct_idx = 4'd0;
			8'h29:   punct_idx = 4'd1;
			8'h7B:   punct_idx = 4'd2;
			8'h7D:   punct_idx = 4'd3;
			8'h3B:   punct_idx = 4'd4;
			8'h2C:   punct_idx = 4'd5;
			8'h2E:   punct_idx = 4'd6;
			8'h2D:   punct_idx = 4'd7;
			8'h2B:   punct_idx = 4'd8;
			8'h2F:   punct_idx = 4'd9;
			8'h2A:   punct_idx = 4'd10;
			default: begin
				punct_idx = 4'd0;
				punct_hit = 1'b0;
			end
		endcase
		op_hit = 1'b1;
		case (c)
			8'h21:   op_idx = 2'd0;
			CH_EQ:   op_idx = 2'd1;
			8'h3C:   op_idx = 2'd2;
			8'h3E:   op_idx = 2'd3;
			default: begin
				op_idx = 2'd0;
				op_hit = 1'b0;
			end
		endcase
	end

	// Next state and emitted tokens for the current byte
	always_comb begin
		logic                 rescan;
		logic                 start_en;
		logic [1:0]           cnt;
		logic [POS_WIDTH-1:0] p;
		logic [15:0]          p_off;
		logic [POS_WIDTH-1:0] dot_pos;
		tok_t [MAX_TOK-1:0]   tk;

		rescan   = 1'b0;
		start_en = 1'b0;
		cnt      = 2'd0;
		tk       = '0;
		p        = cur_pos_q;
		p_off    = 16'(p);
		dot_pos  = p - {{(POS_WIDTH-1){1'b0}}, 1'b1};

		mode_n      = mode_q;
		pend_op_n   = pend_op_q;
		start_pos_n = start_pos_q;
		cur_pos_n   = cur_pos_q;
		kw_prog_n   = kw_prog_q;
		kw_alive_n  = kw_alive_q;
		open_len_n  = open_len_q;

		// Continue the open token
		if (!is_end) begin
			case (mode_q)
				MODE_IDENT: begin
					if (is_alpha || is_digit) begin
						open_len_n = sat_add(open_len_q, 2'd1);
						if (kw_alive_q) begin
							if (kw_prog_q == 2'd1 && c == CH_E)
								kw_prog_n = 2'd2;
							else if (kw_prog_q == 2'd2 && c == CH_T)
								kw_prog_n = 2'd3;
							else
								kw_alive_n = 1'b0;
						end
					end else begin
						rescan = 1'b1;
					end
				end
				MODE_NUM: begin
					if (is_digit)
						open_len_n = sat_add(open_len_q, 2'd1);
					else if (c == CH_DOT)
						mode_n = MODE_NUMDOT;
					else
						rescan = 1'b1;
				end
				MODE_NUMDOT: begin
					if (is_digit) begin
						open_len_n = sat_add(open_len_q, 2'd2);
						mode_n     = MODE_FRAC;
					end else begin
						rescan = 1'b1;
					end
				end
				MODE_FRAC: begin
					if (is_digit)
						open_len_n = sat_add(open_len_q, 2'd1);
					else
						rescan = 1'b1;
				end
				MODE_OP: begin
					if (c == CH_EQ) begin
						tk[cnt] = mk_tok(KIND_OPBASE + {2'b00, pend_op_q, 1'b1},
							16'(start_pos_q), 16'd2);
						cnt     = cnt + 2'd1;
						mode_n  = MODE_IDLE;
					end else begin
						rescan = 1'b1;
					end
				end
				default: start_en = 1'b1;
			endcase
		end

		// Close the open token
		if (is_end || rescan) begin
			case (mode_q)
				MODE_IDENT: begin
					tk[cnt] = mk_tok((kw_alive_q && kw_prog_q == 2'd3) ? KIND_LET : KIND_IDENT,
						16'(start_pos_q), open_len_q);
					cnt     = cnt + 2'd1;
				end
				MODE_NUM, MODE_FRAC: begin
					tk[cnt] = mk_tok(KIND_NUMBER, 16'(start_pos_q), open_len_q);
					cnt     = cnt + 2'd1;
				end
				MODE_NUMDOT: begin
					tk[cnt] = mk_tok(KIND_NUMBER, 16'(start_pos_q), open_len_q);
					cnt     = cnt + 2'd1;
					tk[cnt] = mk_tok(KIND_DOT, 16'(dot_pos), 16'd1);
					cnt     = cnt + 2'd1;
				end
				MODE_OP: begin
					tk[cnt] = mk_tok(KIND_OPBASE + {2'b00, pend_op_q, 1'b0},
						16'(start_pos_q), 16'd1);
					cnt     = cnt + 2'd1;
				end
				default: ;
			endcase
			mode_n = MODE_IDLE;
		end

		// Scan the byte from idle
		if (rescan || start_en) begin
			if (!is_ws) begin
				start_pos_n = p;
				open_len_n  = 16'd1;
				if (is_alpha) begin
					mode_n     = MODE_IDENT;
					kw_alive_n = (c == CH_L);
					kw_prog_n  = 2'd1;
				end else if (is_digit) begin
					mode_n = MODE_NUM;
				end else if (punct_hit) begin
					tk[cnt] = mk_tok({1'b0, punct_idx}, p_off, 16'd1);
					cnt     = cnt + 2'd1;
				end else if (op_hit) begin
					mode_n    = MODE_OP;
					pend_op_n = op_idx;
				end else begin
					tk[cnt] = mk_tok(KIND_ERROR, p_off, 16'd1);
					cnt     = cnt + 2'd1;
				end
			end
		end

		// End of source: eof and restart at offset zero
		if (is_end) begin
			tk[cnt]     = mk_tok(KIND_EOF, p_off, 16'd0);
			cnt         = cnt + 2'd1;
			cur_pos_n   = '0;
			start_pos_n = '0;
			open_len_n  = 16'd0;
			kw_prog_n   = 2'd0;
			kw_alive_n  = 1'b0;
		end else begin
			cur_pos_n = p + {{(POS_WIDTH-1){1'b0}}, 1'b1};
		end

		if (cnt != 2'd0)
			tk[cnt - 2'd1].last_of_run = 1'b1;

		toks    = tk;
		tok_cnt = cnt;
	end

	// Scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			pend_op_q   <= 2'd0;
			start_pos_q <= '0;
			cur_pos_q   <= '0;
			kw_prog_q   <= 2'd0;
			kw_alive_q  <= 1'b0;
			open_len_q  <= 16'd0;
		end else if (step) begin
			mode_q      <= mode_n;
			pend_op_q   <= pend_op_n;
			start_pos_q <= start_pos_n;
			cur_pos_q   <= cur_pos_n;
			kw_prog_q   <= kw_prog_n;
			kw_alive_q  <= kw_alive_n;
			open_len_q  <= open_len_n;
		end
	end

endmodule

`default_nettype wire

// ===== design/bsl_tok_fifo.sv =====
// Token queue: takes up to three tokens a cycle, delivers one a cycle while token_stall is low.
// Depends on bsl_pkg for the token type and queue geometry.
`timescale 1ns / 1ps
`default_nettype none

module bsl_tok_fifo
	import bsl_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [1:0]         push_cnt,
	input  wire tok_t [MAX_TOK-1:0] push_data,
	output logic                    room,
	output logic                    token_valid,
	input  wire logic               token_stall,
	output tok_t                    token
);

	tok_t                mem [TQ_DEPTH];
	logic [TQ_PTR_W-1:0] wptr_q, rptr_q;
	logic [TQ_CNT_W-1:0] cnt_q;
	logic                pop;

	// Room for a full burst of tokens
	assign room        = cnt_q <= TQ_CNT_W'(TQ_DEPTH - MAX_TOK);
	assign token_valid = cnt_q != '0;
	assign token       = mem[rptr_q];
	assign pop         = token_valid && !token_stall;

	// Storage
	always_ff @(posedge clk) begin
		for (int k = 0; k < MAX_TOK; k++) begin
			if (2'(k) < push_cnt)
				mem[wptr_q + TQ_PTR_W'(k)] <= push_data[k];
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			wptr_q <= wptr_q + TQ_PTR_W'(push_cnt);
			rptr_q <= rptr_q + TQ_PTR_W'(pop);
			cnt_q  <= cnt_q + TQ_CNT_W'(push_cnt) - TQ_CNT_W'(pop);
		end
	end

endmodule

`default_nettype wire

// ===== design/byte_stream_lexer_core.sv =====
// Byte stream lexer: turns source bytes into tokens (kind, offset, length).
// A byte waits in the input register and is scanned once the queue has room;
// its tokens are queued and the queue head drives the output. Throughput: one
// byte per cycle while the 8-entry token queue has room for three tokens; the
// output side delivers one token per cycle while token_stall is low. Reset
// clears scanner state and queue. Depends on bsl_pkg, bsl_scan, bsl_tok_fifo.
`timescale 1ns / 1ps
`default_nettype none

module byte_stream_lexer_core
	import bsl_pkg::*;
#(
	parameter int POS_WIDTH = 16
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    byte_valid,
	output logic         byte_stall,
	input  wire in_req_t byte_req,
	output logic         token_valid,
	input  wire logic    token_stall,
	output tok_t         token
);

	logic               valid_s1;
	in_req_t            req_s1;
	logic               room;
	logic               step;
	tok_t [MAX_TOK-1:0] toks;
	logic [1:0]         tok_cnt;

	assign step       = valid_s1 && room;
	assign byte_stall = valid_s1 && !room;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || room) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall)
			req_s1 <= byte_req;
	end

	bsl_scan #(
		.POS_WIDTH(POS_WIDTH)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.req     (req_s1),
		.toks    (toks),
		.tok_cnt (tok_cnt)
	);

	bsl_tok_fifo u_fifo (
		.clk         (clk),
		.arst_n      (arst_n),
		.push_cnt    (step ? tok_cnt : 2'd0),
		.push_data   (toks),
		.room        (room),
		.token_valid (token_valid),
		.token_stall (token_stall),
		.token       (token)
	);

endmodule

`default_nettype wire

// ===== design/bsl_checker.sv =====
// Port-level checks for the byte stream lexer, bound to the top level.
// Depends on bsl_pkg and byte_stream_lexer_core_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "byte_stream_lexer_core_assert.svh"

module bsl_checker
	import bsl_pkg::*;
(
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    byte_valid,
	input wire logic    byte_stall,
	input wire in_req_t byte_req,
	input wire logic    token_valid,
	input wire logic    token_stall,
	input wire tok_t    token
);

	// A stalled token stays put
	`BSL_ASSERT_NXT(a_tok_hold, token_valid && token_stall, token_valid && $stable(token), "token changed while stalled")

	// EOF closes the run and has no length
	`BSL_ASSERT_IMP(a_eof_shape, token_valid && token.token_kind == KIND_EOF, token.token_length == 16'd0 && token.last_of_run, "malformed eof token")

	// Single punctuators and errors span one byte
	`BSL_ASSERT_IMP(a_single_len, token_valid && (token.token_kind < KIND_OPBASE || token.token_kind == KIND_ERROR), token.token_length == 16'd1, "single-byte token with wrong length")

	// Operators with a trailing equal sign span two bytes
	`BSL_ASSERT_IMP(a_opeq_len, token_valid && (token.token_kind == KIND_BANG_EQ || token.token_kind == KIND_EQ_EQ || token.token_kind == KIND_LESS_EQ || token.token_kind == KIND_GREATER_EQ), token.token_length == 16'd2, "two-byte operator with wrong length")

endmodule

bind byte_stream_lexer_core bsl_checker u_bsl_checker (.*);

`default_nettype wire

// ===== tb/lexer_token_checker.sv =====
// Token checker for the byte stream lexer: watches both channels, predicts
// the tokens of each accepted byte and compares them in order.
// Depends on bsl_pkg.
`timescale 1ns / 1ps

module lexer_token_checker
	import bsl_pkg::*;
#(
	parameter int POS_WIDTH = 16
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    byte_valid,
	input  wire logic    byte_stall,
	input  wire in_req_t byte_req,
	input  wire logic    token_valid,
	input  wire logic    token_stall,
	input  wire tok_t    token,
	output int           mismatches,
	output int           tokens_due
);

	typedef enum logic [5:0] {
		SCAN_IDLE     = 6'b000001,
		SCAN_IDENT    = 6'b000010,
		SCAN_NUMBER   = 6'b000100,
		SCAN_NUM_DOT  = 6'b001000,
		SCAN_FRACTION = 6'b010000,
		SCAN_OPERATOR = 6'b100000
	} scan_mode_t;

	// How far an identifier has matched the keyword
	localparam logic [1:0] KW_NONE   = 2'd0;
	localparam logic [1:0] KW_L_SEEN = 2'd1;
	localparam logic [1:0] KW_E_SEEN = 2'd2;
	localparam logic [1:0] KW_T_SEEN = 2'd3;

	// Index in these tables is the token kind / operator code
	localparam logic [7:0] PUNCT_CHARS [11] = '{"(", ")", "{", "}", ";", ",", ".", "-", "+",
		"/", "*"};
	localparam logic [7:0] OP_CHARS [4] = '{"!", "=", "<", ">"};

	// Scanner copy
	scan_mode_t           mode;
	logic [1:0]           pend_op;
	logic [POS_WIDTH-1:0] tok_start;
	logic [POS_WIDTH-1:0] cur_pos;
	logic [1:0]           kw_progress;
	logic                 kw_alive;
	logic [15:0]          open_len;

	tok_t step_tokens[$];
	tok_t due_tokens[$];

	function automatic bit is_letter(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDERSCORE;
	endfunction

	function automatic bit is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_blank(logic [7:0] c);
		return c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A;
	endfunction

	function automatic void reset_scanner();
		mode = SCAN_IDLE;
		pend_op = '0;
		tok_start = '0;
		cur_pos = '0;
		kw_progress = KW_NONE;
		kw_alive = 1'b0;
		open_len = '0;
	endfunction

	function automatic void emit(logic [4:0] kind, logic [POS_WIDTH-1:0] off, logic [15:0] len);
		tok_t t;
		t.token_kind = kind;
		t.token_offset = 16'(off);
		t.token_length = len;
		t.last_of_run = 1'b0;
		step_tokens.push_back(t);
	endfunction

	// Open token length saturates
	function automatic void grow_token(logic [1:0] by);
		logic [16:0] sum;
		sum = {1'b0, open_len} + 17'(by);
		open_len = (sum > 17'(LEN_MAX)) ? LEN_MAX : sum[15:0];
	endfunction

	// Close whatever token is open
	function automatic void close_token();
		case (mode)
			SCAN_IDENT: begin
				emit((kw_alive && kw_progress == KW_T_SEEN) ? KIND_LET : KIND_IDENT,
					tok_start, open_len);
			end
			SCAN_NUMBER, SCAN_FRACTION: begin
				emit(KIND_NUMBER, tok_start, open_len);
			end
			SCAN_NUM_DOT: begin
				// dot never got its fraction digit
				emit(KIND_NUMBER, tok_start, open_len);
				emit(KIND_DOT, cur_pos - 1'b1, 16'd1);
			end
			SCAN_OPERATOR: begin
				emit(KIND_OPBASE + 5'(2 * pend_op), tok_start, 16'd1);
			end
			default: ;
		endcase
		mode = SCAN_IDLE;
	endfunction

	// Scan a byte from idle
	function automatic void open_token(logic [7:0] c, logic [POS_WIDTH-1:0] p);
		if (is_blank(c))
			return;
		tok_start = p;
		open_len = 16'd1;
		if (is_letter(c)) begin
			mode = SCAN_IDENT;
			kw_alive = (c == CH_L);
			kw_progress = KW_L_SEEN;
			return;
		end
		if (is_digit(c)) begin
			mode = SCAN_NUMBER;
			return;
		end
		for (int i = 0; i < 11; i++) begin
			if (c == PUNCT_CHARS[i]) begin
				emit(5'(i), p, 16'd1);
				return;
			end
		end
		for (int i = 0; i < 4; i++) begin
			if (c == OP_CHARS[i]) begin
				mode = SCAN_OPERATOR;
				pend_op = 2'(i);
				return;
			end
		end
		emit(KIND_ERROR, p, 16'd1);
	endfunction

	// Tokens caused by one accepted byte go to the due queue
	function automatic void lex_byte(logic [7:0] c, logic eoi);
		logic [POS_WIDTH-1:0] p;
		bit rescan;
		p = cur_pos;
		rescan = 0;
		step_tokens.delete();
		if (eoi || c == CH_NUL) begin
			close_token();
			emit(KIND_EOF, p, 16'd0);
			cur_pos = '0;
			tok_start = '0;
			open_len = '0;
			kw_progress = KW_NONE;
			kw_alive = 1'b0;
		end else begin
			case (mode)
				SCAN_IDENT: begin
					if (is_letter(c) || is_digit(c)) begin
						grow_token(2'd1);
						if (kw_alive) begin
							if (kw_progress == KW_L_SEEN && c == CH_E)
								kw_progress = KW_E_SEEN;
							else if (kw_progress == KW_E_SEEN && c == CH_T)
								kw_progress = KW_T_SEEN;
							else
								kw_alive = 1'b0;
						end
					end else begin
						rescan = 1;
					end
				end
				SCAN_NUMBER: begin
					if (is_digit(c))
						grow_token(2'd1);
					else if (c == CH_DOT)
						mode = SCAN_NUM_DOT;
					else
						rescan = 1;
				end
				SCAN_NUM_DOT: begin
					if (is_digit(c)) begin
						grow_token(2'd2);
						mode = SCAN_FRACTION;
					end else begin
						rescan = 1;
					end
				end
				SCAN_FRACTION: begin
					if (is_digit(c))
						grow_token(2'd1);
					else
						rescan = 1;
				end
				SCAN_OPERATOR: begin
					if (c == CH_EQ) begin
						emit(KIND_OPBASE + 5'(2 * pend_op) + 5'd1, tok_start, 16'd2);
						mode = SCAN_IDLE;
					end else begin
						rescan = 1;
					end
				end
				default: begin
					open_token(c, p);
				end
			endcase
			if (rescan) begin
				close_token();
				open_token(c, p);
			end
			cur_pos = p + 1'b1;
		end
		if (step_tokens.size() > 0)
			step_tokens[step_tokens.size() - 1].last_of_run = 1'b1;
		foreach (step_tokens[i])
			due_tokens.push_back(step_tokens[i]);
	endfunction

	function automatic void report_field(string field, int want, int got);
		if (want != got)
			$display("%0t: token %s expected %0d actual %0d", $time, field, want, got);
	endfunction

	initial begin
		mismatches = 0;
		tokens_due = 0;
		reset_scanner();
	end

	// Compare delivered tokens, then predict from the accepted request
	always @(posedge clk) begin
		tok_t want;
		if (arst_n) begin
			if (token_valid && !token_stall) begin
				if (due_tokens.size() == 0) begin
					$display("%0t: token expected none actual kind %0d offset %0d length %0d last %0b",
						$time, token.token_kind, token.token_offset, token.token_length,
						token.last_of_run);
					mismatches++;
				end else begin
					want = due_tokens.pop_front();
					if (token !== want) begin
						mismatches++;
						report_field("kind", want.token_kind, token.token_kind);
						report_field("offset", want.token_offset, token.token_offset);
						report_field("length", want.token_length, token.token_length);
						report_field("last", want.last_of_run, token.last_of_run);
						if ($isunknown(token))
							$display("%0t: token expected %h actual %h", $time, want, token);
					end
				end
			end
			if (byte_valid && !byte_stall)
				lex_byte(byte_req.input_byte, byte_req.end_of_input);
		end else begin
			reset_scanner();
			due_tokens.delete();
		end
		tokens_due = due_tokens.size();
	end

endmodule

// ===== tb/tb_byte_stream_lexer_core.sv =====
// Testbench top for byte_stream_lexer_core: drives source bytes and token
// stalls, runs the phases and gives the verdict. Depends on bsl_pkg, the
// lexer RTL and lexer_token_checker.
`timescale 1ns / 1ps

module tb_byte_stream_lexer_core;
	import bsl_pkg::*;

	localparam int    HOLD_CYCLES  = 80;
	localparam int    RANDOM_ITEMS = 90;
	localparam int    CALM_ITEMS   = 25;
	localparam string LETTERS      = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
	localparam string ALNUM        = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
	localparam string DIGITS       = "0123456789";
	localparam string PUNCT        = "(){};,.-+/*";
	localparam string OPERATORS    = "!=<>";
	localparam string BLANKS       = " \t\r\n";
	localparam string STRAY        = "#$@~?:[]^|&%'\\\"";

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    byte_valid = 1'b0;
	logic    byte_stall;
	in_req_t byte_req = '0;
	logic    token_valid;
	logic    token_stall = 1'b0;
	tok_t    token;

	int mismatches;
	int tokens_due;
	int bytes_sent = 0;
	int send_idle_pct = 25;
	int recv_stall_pct = 25;
	bit quiet = 0;
	bit hold_req = 0;

	byte_stream_lexer_core #(.POS_WIDTH(16)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_req(byte_req),
		.token_valid(token_valid),
		.token_stall(token_stall),
		.token(token)
	);

	lexer_token_checker #(.POS_WIDTH(16)) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_req(byte_req),
		.token_valid(token_valid),
		.token_stall(token_stall),
		.token(token),
		.mismatches(mismatches),
		.tokens_due(tokens_due)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop
	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

	// Token side: random stall bursts, plus one long hold-off on request
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 0;
				token_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				token_stall = 1'b0;
			end else if (!quiet && $urandom_range(0, 99) < recv_stall_pct) begin
				token_stall = 1'b1;
				repeat ($urandom_range(1, 9)) @(negedge clk);
				token_stall = 1'b0;
			end
		end
	end

	function automatic logic [7:0] pick_char(input string s);
		return s[$urandom_range(0, s.len() - 1)];
	endfunction

	// Called and returns at a falling edge; valid stays high on return
	task automatic send_byte(input logic [7:0] b, input logic eoi);
		if (!quiet && send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
			byte_valid = 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		byte_valid = 1'b1;
		byte_req.input_byte = b;
		byte_req.end_of_input = eoi;
		do @(posedge clk); while (byte_stall);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], 1'b0);
	endtask

	// End request; the byte it carries is ignored
	task automatic send_end();
		send_byte(8'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic drain_tokens();
		byte_valid = 1'b0;
		wait (tokens_due == 0);
		@(negedge clk);
	endtask

	// One mostly well-formed lexeme, some noise
	task automatic send_lexeme();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 25) begin
			if ($urandom_range(0, 3) == 0) begin
				case ($urandom_range(0, 4))
					0: send_text("let");
					1: send_text("le");
					2: send_text("lets");
					3: send_text("lxt");
					default: send_text("leT");
				endcase
			end else begin
				send_byte(pick_char(LETTERS), 1'b0);
				repeat ($urandom_range(0, 5)) send_byte(pick_char(ALNUM), 1'b0);
			end
		end else if (roll < 45) begin
			repeat ($urandom_range(1, 4)) send_byte(pick_char(DIGITS), 1'b0);
			if ($urandom_range(0, 1)) begin
				send_byte(CH_DOT, 1'b0);
				repeat ($urandom_range(0, 3)) send_byte(pick_char(DIGITS), 1'b0);
			end
		end else if (roll < 60) begin
			send_byte(pick_char(OPERATORS), 1'b0);
			if ($urandom_range(0, 1))
				send_byte(CH_EQ, 1'b0);
		end else if (roll < 72) begin
			send_byte(pick_char(PUNCT), 1'b0);
		end else if (roll < 82) begin
			repeat ($urandom_range(1, 2)) send_byte(pick_char(BLANKS), 1'b0);
		end else if (roll < 88) begin
			if ($urandom_range(0, 1))
				send_byte(pick_char(STRAY), 1'b0);
			else
				send_byte(8'($urandom_range(128, 255)), 1'b0);
		end else if (roll < 94) begin
			send_byte(8'($urandom_range(0, 255)), 1'b0);
		end else if (roll < 97) begin
			send_end();
		end else begin
			send_byte(CH_NUL, 1'b0);
		end
	endtask

	initial begin
		int start;
		bit paused;
		paused = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: keyword, operators with and without '=', fraction,
		// dangling dots, high and stray bytes, zero byte, end flushes
		send_text("let=1.5<=x_Z9 3..");
		send_byte(8'h80, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_text("~");
		send_byte(CH_NUL, 1'b0);
		send_end();
		send_text("4.");
		send_end();
		drain_tokens();

		// Receiver holds off while requests keep coming, so input backs up
		send_idle_pct = 0;
		hold_req = 1;
		repeat (30) send_byte(pick_char(PUNCT), 1'b0);
		drain_tokens();

		// Random lexemes, idling switched on and off in stretches
		start = bytes_sent;
		while (bytes_sent - start < RANDOM_ITEMS) begin
			if (((bytes_sent - start) / 40) % 2 == 1) begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end else begin
				send_idle_pct = 30;
				recv_stall_pct = 30;
			end
			if (!paused && bytes_sent - start >= RANDOM_ITEMS / 2) begin
				paused = 1;
				drain_tokens();
			end
			send_lexeme();
		end

		// Last part at full rate on both sides
		quiet = 1;
		start = bytes_sent;
		while (bytes_sent - start < CALM_ITEMS)
			send_lexeme();
		send_end();
		byte_valid = 1'b0;

		wait (tokens_due == 0);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== byte_stream_lexer_core.f =====
+incdir+design
design/bsl_pkg.sv
design/bsl_scan.sv
design/bsl_tok_fifo.sv
design/byte_stream_lexer_core.sv
design/bsl_checker.sv
tb/lexer_token_checker.sv
tb/tb_byte_stream_lexer_core.sv
